// ===== hdl/key_tag_quicksort_descending_unit_defines.svh =====
// Assertion macros for the port checker of the quicksort unit.
`ifndef KEY_TAG_QUICKSORT_DESCENDING_UNIT_DEFINES_SVH
`define KEY_TAG_QUICKSORT_DESCENDING_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and idle during reset.
`define KTQS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and idle during reset.
`define KTQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ktqs_pkg.sv =====
// Beat types shared by the quicksort unit and its checker.
package ktqs_pkg;

    typedef struct packed {
        logic [15:0] sort_key;
        logic [15:0] tag;
        logic        batch_end;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] sorted_key;
        logic [15:0] sorted_tag;
        logic        final_pair;
        logic        overflowed;
    } t_out_beat;

endpackage

// ===== hdl/ktqs_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module ktqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/key_tag_quicksort_descending_unit.sv =====
// Top level: batch loader, Hoare quicksort sequencer and sorted-pair emitter.
//
//  channel | direction | handshake                    | beat
//  --------+-----------+------------------------------+---------------------
//  input   | in        | i_in_valid / o_in_stall      | i_in_beat  (t_in_beat)
//  output  | out       | o_out_valid / i_out_stall    | o_out_beat (t_out_beat)
//
//  Loading takes one beat per cycle; o_in_stall stays low only while loading.
//  After the beat marked batch_end the sequencer sorts, with key compares paced
//  by the single read port of the pair store, then emits the pairs one at a
//  time, each read from the store in S_ER and registered in S_EL.
//  Reset (synchronous, active low) clears the sequencer, fill and stack counts
//  and output valid; the stores need no clearing pass, as only written entries
//  are read. An output stall holds the result register, pausing only emission.
module key_tag_quicksort_descending_unit #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ktqs_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ktqs_pkg::t_out_beat  o_out_beat
);

    // Store key width: keys arrive as 16 bits, masked to KEY_BITS.
    localparam int KB  = (KEY_BITS < 16) ? KEY_BITS : 16;
    localparam int DW  = KB + 16;
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = AW + 1;
    localparam int IW  = AW + 2;            // signed scan index, may reach -1
    localparam int SD  = MAX_ITEMS + 2;     // range stack depth
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_POP  = 4'd1;
    localparam logic [3:0] S_POPW = 4'd2;
    localparam logic [3:0] S_PIV  = 4'd3;
    localparam logic [3:0] S_RI   = 4'd4;
    localparam logic [3:0] S_CI   = 4'd5;
    localparam logic [3:0] S_RJ   = 4'd6;
    localparam logic [3:0] S_CJ   = 4'd7;
    localparam logic [3:0] S_SW1  = 4'd8;
    localparam logic [3:0] S_SW2  = 4'd9;
    localparam logic [3:0] S_PR   = 4'd10;
    localparam logic [3:0] S_PL   = 4'd11;
    localparam logic [3:0] S_ER   = 4'd12;
    localparam logic [3:0] S_EL   = 4'd13;

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_fill, n_fill;
    logic                 r_drop, n_drop;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_k, n_k;
    logic [SPW-1:0]       r_sp, n_sp;
    logic signed [IW-1:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j;
    logic [KB-1:0]        r_piv, n_piv;
    logic [DW-1:0]        r_hold_i, n_hold_i, r_hold_j, n_hold_j;
    logic                 r_ovalid, n_ovalid;
    ktqs_pkg::t_out_beat  r_out, n_out;

    // Pair store and range stack ports
    logic            d_we;
    logic [AW-1:0]   d_wa, d_ra;
    logic [DW-1:0]   d_wd, d_rd;
    logic            s_we;
    logic [SAW-1:0]  s_wa, s_ra;
    logic [2*AW-1:0] s_wd, s_rd;

    logic [KB-1:0]        d_key;
    logic [15:0]          d_tag;
    logic                 in_acc;
    logic [CW-1:0]        cnt;
    logic [AW-1:0]        pop_lo, pop_hi, mid;
    logic signed [IW-1:0] ip1, jm1;

    ktqs_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_wa),
        .i_wdata (d_wd),
        .i_raddr (d_ra),
        .o_rdata (d_rd)
    );

    ktqs_ram #(.WIDTH(2 * AW), .DEPTH(SD)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_wa),
        .i_wdata (s_wd),
        .i_raddr (s_ra),
        .o_rdata (s_rd)
    );

    assign d_key  = d_rd[DW-1:16];
    assign d_tag  = d_rd[15:0];
    assign pop_lo = s_rd[2*AW-1:AW];
    assign pop_hi = s_rd[AW-1:0];
    assign mid    = AW'(({1'b0, pop_lo} + {1'b0, pop_hi}) >> 1);
    assign ip1    = r_i + IW'(1);
    assign jm1    = r_j - IW'(1);

    assign o_in_stall  = (r_state != S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_out;

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_drop   = r_drop;
        n_n      = r_n;
        n_k      = r_k;
        n_sp     = r_sp;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_piv    = r_piv;
        n_hold_i = r_hold_i;
        n_hold_j = r_hold_j;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        d_we     = 1'b0;
        d_wa     = '0;
        d_wd     = '0;
        d_ra     = '0;
        s_we     = 1'b0;
        s_wa     = '0;
        s_wd     = '0;
        s_ra     = '0;
        cnt      = r_fill;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    // store while room remains, else drop and flag
                    if (r_fill < CW'(MAX_ITEMS)) begin
                        d_we = 1'b1;
                        d_wa = r_fill[AW-1:0];
                        d_wd = {i_in_beat.sort_key[KB-1:0], i_in_beat.tag};
                        cnt  = r_fill + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_fill = cnt;
                    if (i_in_beat.batch_end) begin
                        n_n = cnt;
                        n_k = '0;
                        if (cnt >= CW'(2)) begin
                            // seed the stack with the whole batch
                            s_we    = 1'b1;
                            s_wa    = '0;
                            s_wd    = {AW'(0), AW'(cnt - CW'(1))};
                            n_sp    = SPW'(1);
                            n_state = S_POP;
                        end else begin
                            n_state = S_ER;
                        end
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_ER;
                end else begin
                    n_sp    = r_sp - SPW'(1);
                    s_ra    = n_sp[SAW-1:0];
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_lo = IW'({1'b0, pop_lo});
                n_hi = IW'({1'b0, pop_hi});
                n_i  = IW'({1'b0, pop_lo});
                n_j  = IW'({1'b0, pop_hi});
                if (pop_lo < pop_hi) begin
                    d_ra    = mid;
                    n_state = S_PIV;
                end else begin
                    n_state = S_POP;
                end
            end
            S_PIV: begin
                n_piv   = d_key;
                n_state = S_RI;
            end
            S_RI: begin
                d_ra    = r_i[AW-1:0];
                n_state = S_CI;
            end
            S_CI: begin
                if (r_i < r_hi && d_key > r_piv) begin
                    n_i     = ip1;
                    n_state = S_RI;
                end else begin
                    n_hold_i = d_rd;
                    n_state  = S_RJ;
                end
            end
            S_RJ: begin
                d_ra    = r_j[AW-1:0];
                n_state = S_CJ;
            end
            S_CJ: begin
                if (r_j > r_lo && r_piv > d_key) begin
                    n_j     = jm1;
                    n_state = S_RJ;
                end else begin
                    n_hold_j = d_rd;
                    n_state  = (r_i <= r_j) ? S_SW1 : S_PR;
                end
            end
            S_SW1: begin
                d_we    = 1'b1;
                d_wa    = r_i[AW-1:0];
                d_wd    = r_hold_j;
                n_state = S_SW2;
            end
            S_SW2: begin
                d_we    = 1'b1;
                d_wa    = r_j[AW-1:0];
                d_wd    = r_hold_i;
                n_i     = ip1;
                n_j     = jm1;
                n_state = (ip1 <= jm1) ? S_RI : S_PR;
            end
            S_PR: begin
                // right range goes on first so the left one pops first
                if (r_i < r_hi && r_sp < SPW'(SD)) begin
                    s_we = 1'b1;
                    s_wa = r_sp[SAW-1:0];
                    s_wd = {r_i[AW-1:0], r_hi[AW-1:0]};
                    n_sp = r_sp + SPW'(1);
                end
                n_state = S_PL;
            end
            S_PL: begin
                if (r_lo < r_j && r_sp < SPW'(SD)) begin
                    s_we = 1'b1;
                    s_wa = r_sp[SAW-1:0];
                    s_wd = {r_lo[AW-1:0], r_j[AW-1:0]};
                    n_sp = r_sp + SPW'(1);
                end
                n_state = S_POP;
            end
            S_ER: begin
                if (r_n == '0) begin
                    n_fill  = '0;
                    n_drop  = 1'b0;
                    n_state = S_LOAD;
                end else if (!r_ovalid || !i_out_stall) begin
                    d_ra    = r_k[AW-1:0];
                    n_state = S_EL;
                end
            end
            S_EL: begin
                n_out.sorted_key = 16'(d_key);
                n_out.sorted_tag = d_tag;
                n_out.final_pair = (r_k == r_n - CW'(1));
                n_out.overflowed = r_drop;
                n_ovalid         = 1'b1;
                if (r_k == r_n - CW'(1)) begin
                    n_fill  = '0;
                    n_drop  = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_ER;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_fill   <= '0;
            r_drop   <= 1'b0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_drop   <= n_drop;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers hold without reset
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_k      <= n_k;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_i      <= n_i;
        r_j      <= n_j;
        r_piv    <= n_piv;
        r_hold_i <= n_hold_i;
        r_hold_j <= n_hold_j;
        r_out    <= n_out;
    end

endmodule

// ===== hdl/ktqs_chk.sv =====
// Port checker for the quicksort unit, bound to the top level.
`include "key_tag_quicksort_descending_unit_defines.svh"

module ktqs_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input ktqs_pkg::t_in_beat  i_in_beat,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ktqs_pkg::t_out_beat o_out_beat
);

    `KTQS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output beat dropped while stalled")
    `KTQS_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_beat), "output beat changed while stalled")
    `KTQS_ASSERT_NEXT(a_busy_after_end, i_in_valid && !o_in_stall && i_in_beat.batch_end, o_in_stall, "input taken straight after batch end")
    `KTQS_ASSERT_NEXT(a_quiet_after_final, o_out_valid && !i_out_stall && o_out_beat.final_pair, !o_out_valid, "result beat after final pair")

endmodule

bind key_tag_quicksort_descending_unit ktqs_chk u_ktqs_chk (.*);

// ===== test/ktqs_sort_checker.sv =====
// Channel monitor, descending quicksort predictor and scoreboard for the sort unit.
`timescale 1ns / 100ps

module ktqs_sort_checker #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  ktqs_pkg::t_in_beat   i_in_beat,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  ktqs_pkg::t_out_beat  i_out_beat,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int STACK_DEPTH = MAX_ITEMS + 2;
    localparam int EXP_DEPTH   = 1024;

    logic [15:0]         batch_keys [MAX_ITEMS];
    logic [15:0]         batch_tags [MAX_ITEMS];
    int                  batch_fill;
    logic                batch_dropped;
    ktqs_pkg::t_out_beat exp_ring [EXP_DEPTH];
    int                  exp_wr;
    int                  exp_rd;

    assign o_pending = exp_wr - exp_rd;

    function automatic void swap_entries(int a, int b);
        logic [15:0] k;
        logic [15:0] t;
        k = batch_keys[a];
        t = batch_tags[a];
        batch_keys[a] = batch_keys[b];
        batch_tags[a] = batch_tags[b];
        batch_keys[b] = k;
        batch_tags[b] = t;
    endfunction

    // Hoare partition with middle pivot; pending ranges kept on a stack, left first
    function automatic void sort_batch_descending(int n);
        int stk_lo [STACK_DEPTH];
        int stk_hi [STACK_DEPTH];
        int sp;
        int lo, hi, i, j;
        logic [15:0] pivot;
        if (n < 2) return;
        sp = 0;
        stk_lo[sp] = 0;
        stk_hi[sp] = n - 1;
        sp++;
        while (sp > 0) begin
            sp--;
            lo = stk_lo[sp];
            hi = stk_hi[sp];
            if (lo < 0 || hi >= n || lo >= hi) continue;
            i = lo;
            j = hi;
            pivot = batch_keys[(lo + hi) / 2];
            do begin
                while (i < hi && batch_keys[i] > pivot) i++;
                while (j > lo && pivot > batch_keys[j]) j--;
                if (i <= j) begin
                    swap_entries(i, j);
                    i++;
                    j--;
                end
            end while (i <= j);
            if (i < hi && sp < STACK_DEPTH) begin
                stk_lo[sp] = i;
                stk_hi[sp] = hi;
                sp++;
            end
            if (lo < j && sp < STACK_DEPTH) begin
                stk_lo[sp] = lo;
                stk_hi[sp] = j;
                sp++;
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        ktqs_pkg::t_out_beat want;
        logic [15:0]         masked;
        if (!i_rst_n) begin
            batch_fill    = 0;
            batch_dropped = 1'b0;
            o_fail_count  = 0;
            exp_wr        = 0;
            exp_rd        = 0;
        end else begin
            // result side first: an expectation pushed this edge cannot be due yet
            if (i_out_valid && !i_out_stall) begin
                if (exp_wr == exp_rd) begin
                    report_mismatch($sformatf("unexpected pair key=%h tag=%h",
                        i_out_beat.sorted_key, i_out_beat.sorted_tag));
                end else begin
                    want = exp_ring[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_out_beat.sorted_key !== want.sorted_key)
                        report_mismatch($sformatf("sorted_key %h, want %h",
                            i_out_beat.sorted_key, want.sorted_key));
                    if (i_out_beat.sorted_tag !== want.sorted_tag)
                        report_mismatch($sformatf("sorted_tag %h, want %h",
                            i_out_beat.sorted_tag, want.sorted_tag));
                    if (i_out_beat.final_pair !== want.final_pair)
                        report_mismatch($sformatf("final_pair %b, want %b",
                            i_out_beat.final_pair, want.final_pair));
                    if (i_out_beat.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %b, want %b",
                            i_out_beat.overflowed, want.overflowed));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                masked = 16'(i_in_beat.sort_key & ((17'h1_0000 >> (16 - KEY_BITS)) - 1));
                if (batch_fill < MAX_ITEMS) begin
                    batch_keys[batch_fill] = masked;
                    batch_tags[batch_fill] = i_in_beat.tag;
                    batch_fill++;
                end else begin
                    batch_dropped = 1'b1;
                end
                if (i_in_beat.batch_end) begin
                    sort_batch_descending(batch_fill);
                    for (int k = 0; k < batch_fill; k++) begin
                        want.sorted_key = batch_keys[k];
                        want.sorted_tag = batch_tags[k];
                        want.final_pair = (k == batch_fill - 1);
                        want.overflowed = batch_dropped;
                        exp_ring[exp_wr % EXP_DEPTH] = want;
                        exp_wr++;
                    end
                    batch_fill    = 0;
                    batch_dropped = 1'b0;
                end
            end
        end
    end
endmodule

// ===== test/tb_key_tag_quicksort_descending_unit.sv =====
// Stimulus, idling phases and verdict for the quicksort unit testbench.
`timescale 1ns / 100ps

module tb_key_tag_quicksort_descending_unit;

    localparam int MAX_ITEMS  = 64;
    localparam int KEY_BITS   = 16;
    localparam int IDLE_LIMIT = 200000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ktqs_pkg::t_in_beat  in_beat = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ktqs_pkg::t_out_beat out_beat;
    int                  fail_count;
    int                  pending;

    // idling percentages of the current phase; hold_off forces a long stall
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_off = 1'b0;
    int         quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    key_tag_quicksort_descending_unit #(
        .MAX_ITEMS(MAX_ITEMS),
        .KEY_BITS (KEY_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    ktqs_sort_checker #(
        .MAX_ITEMS(MAX_ITEMS),
        .KEY_BITS (KEY_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver: random stall per phase, or a solid hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_off) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat moving on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("key_tag_quicksort_descending_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one beat, with a random gap first, and hold it until it is taken;
    // valid stays up so the next beat can follow straight on.
    task automatic send_pair(input logic [15:0] key, input logic [15:0] tag,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{sort_key: key, tag: tag, batch_end: last};
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // Random key drawn from a narrow or a full range, so equal keys are common.
    function automatic logic [15:0] pick_key();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3));
            1: return 16'(16'hFFFF - $urandom_range(3));
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small batches, a few full or over capacity, now and then a two-pair batch.
    task automatic send_random_batch(output int sent);
        int n;
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) n = 0;
        else if (sel < 10) n = MAX_ITEMS + $urandom_range(3);
        else if (sel < 15) n = MAX_ITEMS;
        else n = $urandom_range(1, 12);
        if (n == 0) begin
            send_pair(pick_key(), 16'($urandom), 1'b0);
            send_pair(pick_key(), 16'($urandom), 1'b1);
            sent = 2;
        end else begin
            for (int k = 0; k < n; k++)
                send_pair(pick_key(), 16'($urandom), k == n - 1);
            sent = n;
        end
    endtask

    // Drop valid, then hold the sender until every sorted pair has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int sent;
        int total;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: single pair, extremes, duplicates, reversed
        send_pair(16'h0000, 16'hFFFF, 1'b1);
        send_pair(16'hFFFF, 16'h0000, 1'b1);
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'hFFFF, 16'h0002, 1'b0);
        send_pair(16'h0001, 16'h0003, 1'b0);
        send_pair(16'h0000, 16'h0004, 1'b1);
        for (int k = 0; k < 5; k++)
            send_pair(16'h0005, 16'(16'h0010 + k), k == 4);
        for (int k = 0; k < 5; k++)
            send_pair(16'h0001 << k, 16'(16'hA5A5 ^ k), k == 4);
        // a lone beat with batch_end cannot be empty; a full batch follows, where
        // the batch_end beat is the dropped overflow beat
        for (int k = 0; k < MAX_ITEMS; k++)
            send_pair(16'(16'hAAAA ^ (k * 16'h0101)), 16'(16'h5555 ^ k), 1'b0);
        send_pair(16'hBEEF, 16'hCAFE, 1'b1);
        total = 81;

        // phases: none, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 23) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 85 : 23) : 0;
            for (int b = 0; b < 5; b++) begin
                send_random_batch(sent);
                total += sent;
            end
            // pause the sender until every sorted pair has arrived
            wait_drained();
        end

        // long receiver hold-off while two full batches are offered
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int b = 0; b < 2; b++)
                    for (int k = 0; k < MAX_ITEMS; k++)
                        send_pair(16'($urandom), 16'($urandom), k == MAX_ITEMS - 1);
            end
        join
        total += 2 * MAX_ITEMS;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (total < 480) begin
            send_random_batch(sent);
            total += sent;
        end

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("key_tag_quicksort_descending_unit test passed");
        end else begin
            $display("key_tag_quicksort_descending_unit test failed");
        end
        $finish;
    end
endmodule
